FILE: rtl/scmd_pkg.sv
// Shared constants, types and the quarter-wave sine table of the stereo chorus unit.
`timescale 1ns / 1ps
`default_nettype none
package scmd_pkg;

    localparam int LINE_DEPTH   = 2048;
    localparam int ADDR_W       = $clog2(LINE_DEPTH);
    localparam int SAMPLE_W     = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 25;
    localparam int PHASE_W      = 16;
    localparam int FRAC_W       = 24;
    localparam int DEPTH_W      = 10;
    localparam int LFO_MAG_W    = 25;
    localparam int CNT_W        = 5;
    localparam int QUARTER      = 256;
    localparam int SINE_IDX_W   = 9;

    localparam logic [CNT_W-1:0] MOD_LAST  = CNT_W'(PHASE_W);
    localparam logic [CNT_W-1:0] PMUL_LAST = CNT_W'(PHASE_W - 1);
    localparam logic [CNT_W-1:0] DMUL_LAST = CNT_W'(DEPTH_W - 1);
    localparam logic [CNT_W-1:0] GMUL_LAST = CNT_W'(SAMPLE_W - 1);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WAVEFORM,
        CFG_BASE,
        CFG_DEPTH,
        CFG_GAIN,
        CFG_PERIOD,
        CFG_STEP,
        CFG_OFFSET
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_PMUL,
        ST_LFO,
        ST_DMUL,
        ST_ADDR,
        ST_TAP,
        ST_GMUL,
        ST_WRITE
    } state_t;

    typedef logic [LFO_MAG_W-1:0] sine_tab_t [0:QUARTER];

    function automatic sine_tab_t build_sine();
        logic [63:0] q30;
        logic [63:0] x;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] h;
        logic [63:0] s;
        sine_tab_t   t;
        q30 = 64'd1 << 30;
        for (int j = 0; j <= QUARTER; j++) begin
            x  = 64'(j) << 22;
            z  = (x * 64'd1686629713) >> 30;
            z2 = (z * z) >> 30;
            h  = q30 - z2 / 64'd110;
            h  = q30 - ((z2 * h) >> 30) / 64'd72;
            h  = q30 - ((z2 * h) >> 30) / 64'd42;
            h  = q30 - ((z2 * h) >> 30) / 64'd20;
            h  = q30 - ((z2 * h) >> 30) / 64'd6;
            s  = (z * h) >> 30;
            if (s > q30)
            begin
                s = q30;
            end
            t[j] = s[30:6];
        end
        return t;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

endpackage
`default_nettype wire

FILE: rtl/scmd_channels.sv
// Valid/ready channel interfaces for samples, wet results and register writes.
`timescale 1ns / 1ps
`default_nettype none
interface scmd_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [scmd_pkg::SAMPLE_W-1:0] in_sample;
    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

interface scmd_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [scmd_pkg::SAMPLE_W-1:0] left_wet;
    logic signed [scmd_pkg::SAMPLE_W-1:0] right_wet;
    modport source (output valid, output left_wet, output right_wet, input ready);
    modport sink   (input valid, input left_wet, input right_wet, output ready);
endinterface

interface scmd_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [scmd_pkg::CFG_INDEX_W-1:0]    index;
    logic [scmd_pkg::CFG_DATA_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/stereo_chorus_modulated_delay_unit.sv
// Stereo chorus: one mono sample in, two LFO-modulated delay line taps out.
// Between one acceptance and the next an item passes through 17 restoring
// steps for the right LFO phase modulo the period, 16 shift-add steps for the LFO
// fraction, one table or triangle step, 10 shift-add steps for the depth scaling,
// one line read, one tap select, 16 shift-add steps for the gain and one write-back.
// Both lines work in parallel lanes and each line is a 2048-entry single-port-write
// memory; a fill count stands in for clearing, so the block is ready straight after
// reset. A finished result waits in an output register while the next item is taken.
`timescale 1ns / 1ps
`default_nettype none
module stereo_chorus_modulated_delay_unit (
    input  wire logic     clk,
    input  wire logic     rst_n,
    scmd_in_if.sink       sample_in,
    scmd_out_if.source    wet_out,
    scmd_cfg_if.sink      cfg
);

    localparam int AW = scmd_pkg::ADDR_W;
    localparam int SW = scmd_pkg::SAMPLE_W;
    localparam int PW = scmd_pkg::PHASE_W;
    localparam int FW = scmd_pkg::FRAC_W;
    localparam int DW = scmd_pkg::DEPTH_W;
    localparam int MW = scmd_pkg::LFO_MAG_W;
    localparam int CW = scmd_pkg::CNT_W;

    // configuration
    logic                  waveform_reg;
    logic [DW-1:0]         base_reg;
    logic [DW-1:0]         depth_reg;
    logic [SW-1:0]         gain_reg;
    logic [PW-1:0]         period_cfg_reg;
    logic [FW:0]           step_reg;
    logic [PW-1:0]         offset_reg;

    // control
    scmd_pkg::state_t      state_reg;
    scmd_pkg::state_t      state_next;
    logic [CW-1:0]         cnt_reg;
    logic [AW-1:0]         wi_reg;
    logic [AW:0]           fill_reg;
    logic [PW-1:0]         phase_reg;
    logic                  out_valid_reg;

    // datapath
    logic [SW-1:0]         smp_reg;
    logic [PW-1:0]         pl_reg;
    logic [PW:0]           num_reg;
    logic [PW:0]           rem_reg;
    logic [PW-1:0]         mplier_reg [2];
    logic [FW-1:0]         mcand_reg  [2];
    logic [FW-1:0]         frac_reg   [2];
    logic                  neg_reg    [2];
    logic [DW-1:0]         dml_reg;
    logic [MW+DW-1:0]      dmc_reg    [2];
    logic [MW+DW-1:0]      dacc_reg   [2];
    logic [AW-1:0]         rd_reg     [2];
    logic [SW-1:0]         rdata_reg  [2];
    logic [SW-1:0]         gml_reg;
    logic [2*SW-1:0]       gmc_reg    [2];
    logic [2*SW-1:0]       gacc_reg   [2];
    logic [SW-1:0]         left_reg;
    logic [SW-1:0]         right_reg;

    logic [SW-1:0]         left_line_mem  [scmd_pkg::LINE_DEPTH];
    logic [SW-1:0]         right_line_mem [scmd_pkg::LINE_DEPTH];

    // combinational
    logic [PW-1:0]         period;
    logic [PW-1:0]         pl_start;
    logic [PW:0]           rem_sh;
    logic [PW:0]           rem_next;
    logic                  in_ready;
    logic                  in_take;
    logic                  out_take;
    logic                  write_go;
    logic                  line_we;
    logic [FW-1:0]         facc_next [2];
    logic [FW+2:0]         tri_d     [2];
    logic [FW+2:0]         tri_abs   [2];
    logic [FW+2:0]         tri_v     [2];
    logic [FW+2:0]         tri_vn    [2];
    logic [9:0]            sine_k    [2];
    logic [scmd_pkg::SINE_IDX_W-1:0] sine_idx [2];
    logic                  lfo_neg   [2];
    logic [MW-1:0]         lfo_mag   [2];
    logic [DW-1:0]         offs      [2];
    logic [AW:0]           delay     [2];
    logic [AW-1:0]         rd_addr   [2];
    logic [SW-1:0]         tap       [2];
    logic [2*SW-1:0]       gadd      [2];
    logic [SW:0]           wet_full  [2];
    logic [SW-1:0]         wet       [2];
    logic [SW:0]           sum_full  [2];
    logic [SW-1:0]         line_val  [2];
    logic [PW:0]           phase_inc;

    assign period   = (period_cfg_reg == '0) ? PW'(1) : period_cfg_reg;
    assign pl_start = (phase_reg < period) ? phase_reg : '0;
    assign rem_sh   = {rem_reg[PW-1:0], num_reg[PW]};
    assign rem_next = (rem_sh >= {1'b0, period}) ? (rem_sh - {1'b0, period}) : rem_sh;
    assign phase_inc = {1'b0, pl_reg} + (PW+1)'(1);
    assign in_take  = sample_in.valid && in_ready;
    assign out_take = wet_out.valid && wet_out.ready;
    assign write_go = !out_valid_reg || wet_out.ready;

    assign sample_in.ready  = in_ready;
    assign cfg.ready        = 1'b1;
    assign wet_out.valid    = out_valid_reg;
    assign wet_out.left_wet  = left_reg;
    assign wet_out.right_wet = right_reg;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            facc_next[l] = frac_reg[l] + (mplier_reg[l][0] ? mcand_reg[l] : '0);

            tri_d[l]   = (FW+3)'(1 << (FW + 1)) - {1'b0, frac_reg[l], 2'b00};
            tri_abs[l] = tri_d[l][FW+2] ? ((FW+3)'(0) - tri_d[l]) : tri_d[l];
            tri_v[l]   = (FW+3)'(1 << FW) - tri_abs[l];
            tri_vn[l]  = (FW+3)'(0) - tri_v[l];
            sine_k[l]  = frac_reg[l][FW-1:FW-10];
            sine_idx[l] = sine_k[l][8] ?
                (scmd_pkg::SINE_IDX_W'(scmd_pkg::QUARTER) - {1'b0, sine_k[l][7:0]}) :
                {1'b0, sine_k[l][7:0]};
            if (waveform_reg)
            begin
                lfo_neg[l] = sine_k[l][9];
                lfo_mag[l] = scmd_pkg::SINE_TAB[sine_idx[l]];
            end
            else
            begin
                lfo_neg[l] = tri_v[l][FW+2];
                lfo_mag[l] = tri_v[l][FW+2] ? tri_vn[l][MW-1:0] : tri_v[l][MW-1:0];
            end

            offs[l]    = dacc_reg[l][FW+DW-1:FW];
            delay[l]   = {2'b00, base_reg} +
                         (neg_reg[l] ? ((AW+1)'(0) - {2'b00, offs[l]}) : {2'b00, offs[l]});
            rd_addr[l] = wi_reg - delay[l][AW-1:0];

            if (rd_reg[l] == wi_reg)
            begin
                tap[l] = smp_reg;
            end
            else if ({1'b0, rd_reg[l]} < fill_reg)
            begin
                tap[l] = rdata_reg[l];
            end
            else
            begin
                tap[l] = '0;
            end

            gadd[l] = (cnt_reg == scmd_pkg::GMUL_LAST) ? ((2*SW)'(0) - gmc_reg[l]) : gmc_reg[l];

            wet_full[l] = gacc_reg[l][2*SW-1:SW-1];
            if (wet_full[l][SW] != wet_full[l][SW-1])
            begin
                wet[l] = wet_full[l][SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end
            else
            begin
                wet[l] = wet_full[l][SW-1:0];
            end
            sum_full[l] = {smp_reg[SW-1], smp_reg} + {wet[l][SW-1], wet[l]};
            if (sum_full[l][SW] != sum_full[l][SW-1])
            begin
                line_val[l] = sum_full[l][SW] ? {1'b1, {(SW-1){1'b0}}} :
                                                {1'b0, {(SW-1){1'b1}}};
            end
            else
            begin
                line_val[l] = sum_full[l][SW-1:0];
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scmd_pkg::ST_IDLE:  if (sample_in.valid) state_next = scmd_pkg::ST_MOD;
            scmd_pkg::ST_MOD:   if (cnt_reg == scmd_pkg::MOD_LAST) state_next = scmd_pkg::ST_PMUL;
            scmd_pkg::ST_PMUL:  if (cnt_reg == scmd_pkg::PMUL_LAST) state_next = scmd_pkg::ST_LFO;
            scmd_pkg::ST_LFO:   state_next = scmd_pkg::ST_DMUL;
            scmd_pkg::ST_DMUL:  if (cnt_reg == scmd_pkg::DMUL_LAST) state_next = scmd_pkg::ST_ADDR;
            scmd_pkg::ST_ADDR:  state_next = scmd_pkg::ST_TAP;
            scmd_pkg::ST_TAP:   state_next = scmd_pkg::ST_GMUL;
            scmd_pkg::ST_GMUL:  if (cnt_reg == scmd_pkg::GMUL_LAST) state_next = scmd_pkg::ST_WRITE;
            scmd_pkg::ST_WRITE: if (write_go) state_next = scmd_pkg::ST_IDLE;
            default:            state_next = scmd_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        line_we  = 1'b0;
        unique case (state_reg)
            scmd_pkg::ST_IDLE:  in_ready = 1'b1;
            scmd_pkg::ST_WRITE: line_we  = write_go;
            default:
            begin
                in_ready = 1'b0;
                line_we  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg   <= 1'b0;
            base_reg       <= '0;
            depth_reg      <= '0;
            gain_reg       <= '0;
            period_cfg_reg <= PW'(1);
            step_reg       <= '0;
            offset_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                scmd_pkg::CFG_WAVEFORM: waveform_reg   <= cfg.data[0];
                scmd_pkg::CFG_BASE:     base_reg       <= cfg.data[DW-1:0];
                scmd_pkg::CFG_DEPTH:    depth_reg      <= cfg.data[DW-1:0];
                scmd_pkg::CFG_GAIN:     gain_reg       <= cfg.data[SW-1:0];
                scmd_pkg::CFG_PERIOD:   period_cfg_reg <= cfg.data[PW-1:0];
                scmd_pkg::CFG_STEP:     step_reg       <= cfg.data[FW:0];
                scmd_pkg::CFG_OFFSET:   offset_reg     <= cfg.data[PW-1:0];
                default:                waveform_reg   <= waveform_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scmd_pkg::ST_IDLE;
            cnt_reg       <= '0;
            wi_reg        <= '0;
            fill_reg      <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (line_we)
            begin
                out_valid_reg <= 1'b1;
                wi_reg        <= wi_reg + AW'(1);
                if (fill_reg != (AW+1)'(scmd_pkg::LINE_DEPTH))
                begin
                    fill_reg <= fill_reg + (AW+1)'(1);
                end
                phase_reg <= (phase_inc >= {1'b0, period}) ? '0 : phase_inc[PW-1:0];
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            scmd_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    smp_reg <= sample_in.in_sample;
                    pl_reg  <= pl_start;
                    num_reg <= {1'b0, pl_start} + {1'b0, offset_reg};
                    rem_reg <= '0;
                end
            end
            scmd_pkg::ST_MOD:
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[PW-1:0], 1'b0};
                mplier_reg[0] <= pl_reg;
                mplier_reg[1] <= rem_next[PW-1:0];
                for (int l = 0; l < 2; l++)
                begin
                    mcand_reg[l] <= step_reg[FW-1:0];
                    frac_reg[l]  <= '0;
                end
            end
            scmd_pkg::ST_PMUL:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    frac_reg[l]   <= facc_next[l];
                    mcand_reg[l]  <= {mcand_reg[l][FW-2:0], 1'b0};
                    mplier_reg[l] <= {1'b0, mplier_reg[l][PW-1:1]};
                end
            end
            scmd_pkg::ST_LFO:
            begin
                dml_reg <= depth_reg;
                for (int l = 0; l < 2; l++)
                begin
                    neg_reg[l]  <= lfo_neg[l];
                    dmc_reg[l]  <= {{DW{1'b0}}, lfo_mag[l]};
                    dacc_reg[l] <= '0;
                end
            end
            scmd_pkg::ST_DMUL:
            begin
                dml_reg <= {1'b0, dml_reg[DW-1:1]};
                for (int l = 0; l < 2; l++)
                begin
                    if (dml_reg[0])
                    begin
                        dacc_reg[l] <= dacc_reg[l] + dmc_reg[l];
                    end
                    dmc_reg[l] <= {dmc_reg[l][MW+DW-2:0], 1'b0};
                end
            end
            scmd_pkg::ST_ADDR:
            begin
                for (int l = 0; l < 2; l++)
                begin
                    rd_reg[l] <= rd_addr[l];
                end
            end
            scmd_pkg::ST_TAP:
            begin
                gml_reg <= gain_reg;
                for (int l = 0; l < 2; l++)
                begin
                    gmc_reg[l]  <= {{SW{tap[l][SW-1]}}, tap[l]};
                    gacc_reg[l] <= '0;
                end
            end
            scmd_pkg::ST_GMUL:
            begin
                gml_reg <= {1'b0, gml_reg[SW-1:1]};
                for (int l = 0; l < 2; l++)
                begin
                    if (gml_reg[0])
                    begin
                        gacc_reg[l] <= gacc_reg[l] + gadd[l];
                    end
                    gmc_reg[l] <= {gmc_reg[l][2*SW-2:0], 1'b0};
                end
            end
            scmd_pkg::ST_WRITE:
            begin
                if (write_go)
                begin
                    left_reg  <= wet[0];
                    right_reg <= wet[1];
                end
            end
            default:
            begin
                smp_reg <= smp_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == scmd_pkg::ST_ADDR)
        begin
            rdata_reg[0] <= left_line_mem[rd_addr[0]];
            rdata_reg[1] <= right_line_mem[rd_addr[1]];
        end
        if (line_we)
        begin
            left_line_mem[wi_reg]  <= line_val[0];
            right_line_mem[wi_reg] <= line_val[1];
        end
    end

    a_out_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == scmd_pkg::ST_WRITE))
        else $error("result appeared without a write-back");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= (AW+1)'(scmd_pkg::LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_right_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == scmd_pkg::ST_PMUL && cnt_reg == '0) |-> (mplier_reg[1] < period))
        else $error("right phase not reduced below period");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !wet_out.ready) |=> out_valid_reg && $stable(left_reg))
        else $error("pending result lost");

endmodule
`default_nettype wire

FILE: tb/stereo_chorus_modulated_delay_unit_tb.sv
// Self-checking testbench of the stereo chorus unit: random stimulus, predicted wet items.
`timescale 1ns / 1ps
`default_nettype none
module stereo_chorus_modulated_delay_unit_tb;

    localparam int          LIMIT       = 2_000_000;
    localparam int          ITEMS       = 1550;
    localparam longint      Q24         = 64'sd1 << 24;
    localparam longint unsigned Q30     = 64'd1 << 30;
    localparam longint unsigned HALF_PI = 64'd1686629713;

    class wet_board;
        bit signed [15:0] left_line [0:scmd_pkg::LINE_DEPTH-1];
        bit signed [15:0] right_line [0:scmd_pkg::LINE_DEPTH-1];
        int unsigned      wr_idx;
        int unsigned      phase;
        bit               wave;
        int unsigned      base;
        int unsigned      depth;
        longint           gain;
        int unsigned      period;
        int unsigned      step;
        int unsigned      offset;
        bit signed [15:0] left_q [$];
        bit signed [15:0] right_q [$];
        int               fails;

        function new();
            foreach (left_line[i])
            begin
                left_line[i]  = '0;
                right_line[i] = '0;
            end
            wr_idx = 0;
            phase  = 0;
            wave   = 0;
            base   = 0;
            depth  = 0;
            gain   = 0;
            period = 1;
            step   = 0;
            offset = 0;
            fails  = 0;
        endfunction

        function void set_reg(scmd_pkg::cfg_idx_t idx,
                              logic [scmd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                scmd_pkg::CFG_WAVEFORM: wave   = data[0];
                scmd_pkg::CFG_BASE:     base   = 32'(data[9:0]);
                scmd_pkg::CFG_DEPTH:    depth  = 32'(data[9:0]);
                scmd_pkg::CFG_GAIN:     gain   = longint'($signed(data[15:0]));
                scmd_pkg::CFG_PERIOD:   period = 32'(data[15:0]);
                scmd_pkg::CFG_STEP:     step   = 32'(data);
                scmd_pkg::CFG_OFFSET:   offset = 32'(data[15:0]);
                default: ;
            endcase
        endfunction

        function longint lfo_val(longint unsigned f);
            longint          d;
            longint unsigned k, q4, quad, r, x, z, z2, h, s;
            if (!wave)
            begin
                d = 2 * Q24 - longint'(f * 4);
                if (d < 0)
                begin
                    d = -d;
                end
                return Q24 - d;
            end
            k    = (f * 1024) >> 24;
            q4   = k * 4;
            quad = q4 / 1024;
            r    = q4 - quad * 1024;
            x    = (r << 30) / 1024;
            if (quad[0])
            begin
                x = Q30 - x;
            end
            z  = (x * HALF_PI) >> 30;
            z2 = (z * z) >> 30;
            h  = Q30 - z2 / 110;
            h  = Q30 - ((z2 * h) >> 30) / 72;
            h  = Q30 - ((z2 * h) >> 30) / 42;
            h  = Q30 - ((z2 * h) >> 30) / 20;
            h  = Q30 - ((z2 * h) >> 30) / 6;
            s  = (z * h) >> 30;
            if (s > Q30)
            begin
                s = Q30;
            end
            return (quad >= 2) ? -longint'(s >> 6) : longint'(s >> 6);
        endfunction

        function longint tap_delay(int unsigned ph);
            longint unsigned f;
            f = (longint'(ph) * longint'(step)) & 64'hFF_FFFF;
            return longint'(base) + (lfo_val(f) * longint'(depth)) / Q24;
        endfunction

        function longint clamp16(longint v);
            if (v > 32767)
            begin
                return 32767;
            end
            if (v < -32768)
            begin
                return -32768;
            end
            return v;
        endfunction

        function bit signed [15:0] run_lane(bit left, longint x, longint dly);
            int unsigned rd;
            longint      p, wet;
            rd = 32'((longint'(wr_idx) - dly) & (scmd_pkg::LINE_DEPTH - 1));
            if (left)
            begin
                left_line[wr_idx] = 16'(x);
                p = longint'(left_line[rd]) * gain;
            end
            else
            begin
                right_line[wr_idx] = 16'(x);
                p = longint'(right_line[rd]) * gain;
            end
            wet = clamp16(p >>> 15);
            if (left)
            begin
                left_line[wr_idx] = 16'(clamp16(x + wet));
            end
            else
            begin
                right_line[wr_idx] = 16'(clamp16(x + wet));
            end
            return 16'(wet);
        endfunction

        function void note_sample(bit signed [15:0] smp);
            int unsigned per, pl, pr;
            longint      dl, dr;
            per = (period == 0) ? 1 : period;
            pl  = (phase < per) ? phase : 0;
            pr  = 32'((longint'(pl) + offset) % per);
            dl  = tap_delay(pl);
            dr  = tap_delay(pr);
            left_q.push_back(run_lane(1, smp, dl));
            right_q.push_back(run_lane(0, smp, dr));
            wr_idx = (wr_idx + 1) & (scmd_pkg::LINE_DEPTH - 1);
            pl++;
            phase = (pl >= per) ? 0 : pl;
        endfunction

        function void check_wet(bit signed [15:0] l, bit signed [15:0] r);
            bit signed [15:0] el, er;
            if (left_q.size() == 0)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("unexpected wet item left=%0d right=%0d", l, r);
                end
                return;
            end
            el = left_q.pop_front();
            er = right_q.pop_front();
            if (el !== l || er !== r)
            begin
                fails++;
                if (fails <= 10)
                begin
                    $display("wet mismatch: expected left=%0d right=%0d, got left=%0d right=%0d",
                             el, er, l, r);
                end
            end
        endfunction

        function int pending();
            return left_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    scmd_in_if  sample_if ();
    scmd_out_if wet_if ();
    scmd_cfg_if cfg_if ();

    stereo_chorus_modulated_delay_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_in (sample_if.sink),
        .wet_out   (wet_if.source),
        .cfg       (cfg_if.sink)
    );

    wet_board board;
    int       hold_req;
    bit       calm;
    int       sent;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT) @(posedge clk);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int pick_gap();
        if (calm)
        begin
            return 0;
        end
        return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(10, 60);
    endfunction

    initial
    begin
        int hold_left;
        hold_left = 0;
        wet_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (wet_if.valid && wet_if.ready)
            begin
                board.check_wet(wet_if.left_wet, wet_if.right_wet);
            end
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                wet_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold_left = pick_gap();
                wet_if.ready <= 1'b0;
            end
            else
            begin
                wet_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_sample(bit signed [15:0] smp, bit no_gap);
        int g;
        g = no_gap ? 0 : pick_gap();
        if (g > 0)
        begin
            sample_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        sample_if.valid     <= 1'b1;
        sample_if.in_sample <= smp;
        do @(posedge clk); while (!sample_if.ready);
        board.note_sample(smp);
        sent++;
    endtask

    task automatic drain();
        sample_if.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() > 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic cfg_write(scmd_pkg::cfg_idx_t idx, logic [scmd_pkg::CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge clk); while (!cfg_if.ready);
        board.set_reg(idx, data);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_all(bit w, int b, int d, int gn, int per, int st, int off);
        cfg_write(scmd_pkg::CFG_WAVEFORM, scmd_pkg::CFG_DATA_W'(w));
        cfg_write(scmd_pkg::CFG_BASE, scmd_pkg::CFG_DATA_W'(b));
        cfg_write(scmd_pkg::CFG_DEPTH, scmd_pkg::CFG_DATA_W'(d));
        cfg_write(scmd_pkg::CFG_GAIN, scmd_pkg::CFG_DATA_W'(gn & 16'hFFFF));
        cfg_write(scmd_pkg::CFG_PERIOD, scmd_pkg::CFG_DATA_W'(per));
        cfg_write(scmd_pkg::CFG_STEP, scmd_pkg::CFG_DATA_W'(st));
        cfg_write(scmd_pkg::CFG_OFFSET, scmd_pkg::CFG_DATA_W'(off));
    endtask

    function automatic bit signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic int pick_ten();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1023;
            2:       return $urandom_range(0, 15);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    initial
    begin
        int per, st, n;
        board    = new();
        hold_req = 0;
        calm     = 0;
        sent     = 0;
        rst_n    = 1'b0;
        sample_if.valid     = 1'b0;
        sample_if.in_sample = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = scmd_pkg::CFG_WAVEFORM;
        cfg_if.data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(16'sh7FFF, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh0000, 0);

        // full negative gain with zero delay
        drain();
        cfg_all(0, 0, 0, -32768, 1, 0, 0);
        send_sample(16'sh8000, 0);
        send_sample(16'sh7FFF, 0);
        send_sample(16'shFFFF, 0);

        // zero period holds both lanes at phase zero despite the deep swing and large step
        drain();
        cfg_all(1, 0, 1023, 32767, 0, 25'h1FF_FFFF, 5);
        send_sample(16'sh4000, 0);
        send_sample(16'shC000, 0);

        drain();
        cfg_all(0, 3, 1023, 20000, 100, 16777216, 250);
        repeat (4) send_sample(rand_sample(), 0);

        drain();
        cfg_all(1, 1023, 1023, -20000, 100, 167772, 70);
        repeat (6) send_sample(rand_sample(), 0);

        // phase now beyond the shorter period
        drain();
        cfg_write(scmd_pkg::CFG_PERIOD, scmd_pkg::CFG_DATA_W'(3));
        repeat (4) send_sample(rand_sample(), 0);

        // long receiver hold while the sender keeps offering items
        drain();
        cfg_all(0, 10, 8, 16384, 50, 335544, 25);
        hold_req = 800;
        calm = 1;
        repeat (40) send_sample(rand_sample(), 1);
        calm = 0;

        while (sent < ITEMS)
        begin
            drain();
            case ($urandom_range(0, 7))
                0:       per = 0;
                1:       per = 65535;
                2:       per = $urandom_range(1, 65535);
                default: per = $urandom_range(1, 300);
            endcase
            case ($urandom_range(0, 5))
                0:       st = 0;
                1:       st = 16777216;
                2:       st = $urandom() & 25'h1FF_FFFF;
                default: st = $urandom_range(1, 16777216) / (per + 1);
            endcase
            cfg_all($urandom_range(0, 1), pick_ten(), pick_ten(), $urandom(), per, st,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, per));
            calm = ($urandom_range(0, 4) == 0);
            n = $urandom_range(80, 140);
            repeat (n) send_sample(rand_sample(), 0);
            calm = 0;
        end

        drain();
        if (board.fails == 0 && board.pending() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
`default_nettype wire
